// File: design/box_field_smooth_union_unit_defines.svh
// ----------------------------------------------------------------------------
// box field smooth union assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef BOX_FIELD_SMOOTH_UNION_UNIT_DEFINES_SVH
`define BOX_FIELD_SMOOTH_UNION_UNIT_DEFINES_SVH

// consequence holds in the same cycle
`define BFSU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the next cycle
`define BFSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bfsu_pkg.sv
// ----------------------------------------------------------------------------
// bfsu_pkg
// types, constants and tables of the box field smooth union unit
// ----------------------------------------------------------------------------
package bfsu_pkg;

  localparam int DIV_STEPS = 20;
  localparam logic [16:0] EXP_K = 17'd94548;
  localparam logic [15:0] LN_K = 16'd45426;
  localparam logic [31:0] SAT_MAX = 32'h7FFFFFFF;
  localparam logic [31:0] SAT_MIN = 32'h80000000;
  localparam logic [30:0] TEMP_RESET = 31'd65536;
  localparam logic [4:0] EXP_N_LIMIT = 5'd31;

  typedef enum logic {
    REG_TEMPERATURE = 1'b0,
    REG_BOX_COUNT   = 1'b1
  } reg_idx_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef struct packed {
    logic wr;
    logic load_q;
    logic cnt_clr;
    logic cnt_inc;
    logic dist_ld;
    logic min_upd;
    logic sum_clr;
    logic div_ld;
    logic div_step;
    logic exp1;
    logic exp2;
    logic exp3;
    logic ln_ld;
    logic ln_shift;
    logic ln1;
    logic ln2;
    logic ln3;
    logic ln4;
    logic ln5;
    logic res_empty;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic n_zero;
    logic cnt_last;
    logic skip;
    logic norm_top;
    logic out_free;
  } status_t;

  function automatic logic [16:0] exp2_tab(logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] log2_tab(logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

// File: design/bfsu_ram.sv
// ----------------------------------------------------------------------------
// bfsu_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bfsu_ram #(
  parameter int WIDTH = 126,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/bfsu_ctrl.sv
// ----------------------------------------------------------------------------
// bfsu_ctrl
// sequencer for table writes, the two passes over the boxes and the log
// ----------------------------------------------------------------------------
module bfsu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  bfsu_pkg::status_t  st,
  output bfsu_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_P1_RD, S_P1_DST, S_P1_MIN, S_P2_RD, S_P2_DST, S_P2_CHK,
    S_DIV, S_EXP1, S_EXP2, S_EXP3, S_LN_LD, S_LN_NORM,
    S_LN1, S_LN2, S_LN3, S_LN4, S_LN5, S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  div_cnt_r, div_cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    div_cnt_nxt = div_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (!st.is_query) begin
            cmd.wr = 1'b1;
          end else if (st.n_zero) begin
            cmd.res_empty = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.load_q = 1'b1;
            cmd.cnt_clr = 1'b1;
            state_nxt = S_P1_RD;
          end
        end
      end
      S_P1_RD:  state_nxt = S_P1_DST;
      S_P1_DST: begin
        cmd.dist_ld = 1'b1;
        state_nxt = S_P1_MIN;
      end
      S_P1_MIN: begin
        cmd.min_upd = 1'b1;
        if (st.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          cmd.sum_clr = 1'b1;
          state_nxt = S_P2_RD;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt = S_P1_RD;
        end
      end
      S_P2_RD:  state_nxt = S_P2_DST;
      S_P2_DST: begin
        cmd.dist_ld = 1'b1;
        state_nxt = S_P2_CHK;
      end
      S_P2_CHK: begin
        if (st.skip) begin
          if (st.cnt_last) begin
            state_nxt = S_LN_LD;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_nxt = S_P2_RD;
          end
        end else begin
          cmd.div_ld = 1'b1;
          div_cnt_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == 5'(bfsu_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_EXP1;
        end else begin
          div_cnt_nxt = div_cnt_r + 5'd1;
        end
      end
      S_EXP1: begin
        cmd.exp1 = 1'b1;
        state_nxt = S_EXP2;
      end
      S_EXP2: begin
        cmd.exp2 = 1'b1;
        state_nxt = S_EXP3;
      end
      S_EXP3: begin
        cmd.exp3 = 1'b1;
        if (st.cnt_last) begin
          state_nxt = S_LN_LD;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt = S_P2_RD;
        end
      end
      S_LN_LD: begin
        cmd.ln_ld = 1'b1;
        state_nxt = S_LN_NORM;
      end
      S_LN_NORM: begin
        if (st.norm_top) begin
          state_nxt = S_LN1;
        end else begin
          cmd.ln_shift = 1'b1;
        end
      end
      S_LN1: begin
        cmd.ln1 = 1'b1;
        state_nxt = S_LN2;
      end
      S_LN2: begin
        cmd.ln2 = 1'b1;
        state_nxt = S_LN3;
      end
      S_LN3: begin
        cmd.ln3 = 1'b1;
        state_nxt = S_LN4;
      end
      S_LN4: begin
        cmd.ln4 = 1'b1;
        state_nxt = S_LN5;
      end
      S_LN5: begin
        cmd.ln5 = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

// File: design/bfsu_dp.sv
// ----------------------------------------------------------------------------
// bfsu_dp
// box table, distance, divider, exp and log datapath and output register
// ----------------------------------------------------------------------------
module bfsu_dp #(
  parameter int MAX_BOXES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic [199:0]       in_tdata,
  input  logic [0:0]         in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,
  output logic [0:0]         out_tuser,
  input  bfsu_pkg::cmd_t     cmd,
  output bfsu_pkg::status_t  st
);

  localparam int AW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW  = $clog2(MAX_BOXES + 1);
  localparam int SW  = $clog2(MAX_BOXES) + 17;
  localparam int PW  = $clog2(SW);
  localparam int L2W = PW + 17;
  localparam int CRW = L2W + 15;
  localparam int RW  = CRW + 2;
  localparam int QW  = bfsu_pkg::DIV_STEPS;

  function automatic logic [5:0] idx_mod(logic [5:0] v);
    logic [5:0] r;
    r = v;
    for (int k = 5; k >= 0; k--) begin
      if (int'(r) >= (MAX_BOXES << k)) begin
        r = r - 6'(MAX_BOXES << k);
      end
    end
    return r;
  endfunction

  // input fields
  logic [5:0]  box_index;
  logic [31:0] center_x, center_z, query_x, query_z;
  logic [30:0] half_width, half_depth;

  assign box_index  = in_tdata[5:0];
  assign center_x   = in_tdata[37:6];
  assign center_z   = in_tdata[69:38];
  assign half_width = in_tdata[100:70];
  assign half_depth = in_tdata[131:101];
  assign query_x    = in_tdata[163:132];
  assign query_z    = in_tdata[195:164];

  // configuration
  logic [30:0] temperature_r;
  logic [6:0]  box_count_r;
  logic [30:0] t_eff;
  logic [CW-1:0] n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temperature_r <= bfsu_pkg::TEMP_RESET;
      box_count_r <= '0;
    end else if (cfg_we) begin
      unique case (bfsu_pkg::reg_idx_t'(cfg_index))
        bfsu_pkg::REG_TEMPERATURE: temperature_r <= cfg_wdata;
        bfsu_pkg::REG_BOX_COUNT:   box_count_r <= cfg_wdata[6:0];
      endcase
    end
  end

  assign t_eff = (temperature_r == '0) ? 31'd1 : temperature_r;
  assign n_eff = (int'(box_count_r) > MAX_BOXES) ? CW'(MAX_BOXES) : CW'(box_count_r);

  // box table
  logic [AW-1:0]  cnt_r;
  logic [125:0]   rdata;

  bfsu_ram #(.WIDTH(126), .DEPTH(MAX_BOXES)) u_table (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (AW'(idx_mod(box_index))),
    .wdata ({half_depth, half_width, center_z, center_x}),
    .raddr (cnt_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  // per box distance
  logic [31:0] qx_r, qz_r;
  logic signed [32:0] ddx, ddz;
  logic [32:0] adx, adz;
  logic signed [33:0] dx, dz, dbox;
  logic signed [33:0] dist_r, dmin_r;
  logic [33:0] delta;

  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      qx_r <= query_x;
      qz_r <= query_z;
    end
  end

  always_comb begin
    ddx = $signed({qx_r[31], qx_r}) - $signed({rdata[31], rdata[31:0]});
    ddz = $signed({qz_r[31], qz_r}) - $signed({rdata[63], rdata[63:32]});
    adx = ddx[32] ? 33'(-ddx) : 33'(ddx);
    adz = ddz[32] ? 33'(-ddz) : 33'(ddz);
    dx = $signed({1'b0, adx}) - $signed({3'b0, rdata[94:64]});
    dz = $signed({1'b0, adz}) - $signed({3'b0, rdata[125:95]});
    dbox = (dx > dz) ? dx : dz;
  end

  always_ff @(posedge clk) begin
    if (cmd.dist_ld) begin
      dist_r <= dbox;
    end
    if (cmd.min_upd && ((cnt_r == '0) || (dist_r < dmin_r))) begin
      dmin_r <= dist_r;
    end
  end

  assign delta = 34'(dist_r - dmin_r);

  // restoring divider for (delta << 16) / t
  logic [31:0]   rem_r, trial;
  logic [QW-1:0] nb_r, quo_r;
  logic          ge;

  assign trial = {rem_r[30:0], nb_r[QW-1]};
  assign ge = (trial >= {1'b0, t_eff});

  always_ff @(posedge clk) begin
    if (cmd.div_ld) begin
      rem_r <= {2'b0, delta[33:4]};
      nb_r <= {delta[3:0], 16'b0};
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? (trial - {1'b0, t_eff}) : trial;
      nb_r <= {nb_r[QW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  // exp(-x) as 2^-y
  logic [QW+16:0] yprod;
  logic [QW:0]    y_r;
  logic [16:0]    ebase_r, ehi, elo, ev, eterm;
  logic [23:0]    ep_r;
  logic [4:0]     en_r;
  logic [SW-1:0]  sum_r;

  assign yprod = quo_r * bfsu_pkg::EXP_K;
  assign ehi = bfsu_pkg::exp2_tab({1'b0, y_r[15:12]});
  assign elo = bfsu_pkg::exp2_tab({1'b0, y_r[15:12]} + 5'd1);
  assign ev = ebase_r - 17'(ep_r >> 12);
  assign eterm = (en_r >= bfsu_pkg::EXP_N_LIMIT) ? 17'd0 : (ev >> en_r);

  always_ff @(posedge clk) begin
    if (cmd.exp1) begin
      y_r <= yprod[QW+16:16];
    end
    if (cmd.exp2) begin
      ebase_r <= ehi;
      ep_r <= 12'(ehi - elo) * y_r[11:0];
      en_r <= 5'(y_r[QW:16]);
    end
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (cmd.exp3) begin
      sum_r <= sum_r + SW'(eterm);
    end
  end

  // ln of the sum and the final correction
  logic [SW-1:0]     norm_r;
  logic [PW-1:0]     p_r;
  logic [16:0]       lbase_r, lhi, llo;
  logic [24:0]       lp_r;
  logic [L2W-1:0]    l2_r, ln_r;
  logic [L2W+15:0]   lnprod;
  logic [L2W+30:0]   cprod;
  logic [CRW-1:0]    corr_r;
  logic signed [RW-1:0] resw;
  logic [31:0]       res_r;
  logic              empty_r;

  assign llo = bfsu_pkg::log2_tab({1'b0, norm_r[SW-2 -: 4]});
  assign lhi = bfsu_pkg::log2_tab({1'b0, norm_r[SW-2 -: 4]} + 5'd1);
  assign lnprod = l2_r * bfsu_pkg::LN_K;
  assign cprod = t_eff * ln_r;
  assign resw = $signed({{(RW-34){dmin_r[33]}}, dmin_r}) - $signed({2'b0, corr_r});

  always_ff @(posedge clk) begin
    if (cmd.ln_ld) begin
      norm_r <= sum_r;
      p_r <= PW'(SW - 1);
    end else if (cmd.ln_shift) begin
      norm_r <= {norm_r[SW-2:0], 1'b0};
      p_r <= p_r - PW'(1);
    end
    if (cmd.ln1) begin
      lbase_r <= llo;
      lp_r <= 13'(lhi - llo) * norm_r[SW-6 -: 12];
    end
    if (cmd.ln2) begin
      l2_r <= (L2W'(p_r - PW'(16)) << 16) + L2W'(lbase_r) + L2W'(lp_r >> 12);
    end
    if (cmd.ln3) begin
      ln_r <= lnprod[L2W+15:16];
    end
    if (cmd.ln4) begin
      corr_r <= cprod[L2W+30:16];
    end
    if (cmd.res_empty) begin
      res_r <= bfsu_pkg::SAT_MAX;
      empty_r <= 1'b1;
    end else if (cmd.ln5) begin
      empty_r <= 1'b0;
      if (resw > $signed({{(RW-32){1'b0}}, bfsu_pkg::SAT_MAX})) begin
        res_r <= bfsu_pkg::SAT_MAX;
      end else if (resw < $signed({{(RW-32){1'b1}}, bfsu_pkg::SAT_MIN})) begin
        res_r <= bfsu_pkg::SAT_MIN;
      end else begin
        res_r <= resw[31:0];
      end
    end
  end

  // output register
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res_r;
      out_user_r <= empty_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

  // status
  assign st.is_query = (bfsu_pkg::req_t'(in_tuser[0]) == bfsu_pkg::REQ_QUERY);
  assign st.n_zero = (n_eff == '0);
  assign st.cnt_last = ((CW'(cnt_r) + CW'(1)) == n_eff);
  assign st.skip = ({1'b0, delta} >= {t_eff, 4'b0});
  assign st.norm_top = norm_r[SW-1];
  assign st.out_free = !out_valid_r || out_tready;

endmodule

// File: design/box_field_smooth_union_unit.sv
// ----------------------------------------------------------------------------
// box_field_smooth_union_unit
// smooth union distance over a table of 2d boxes
// ----------------------------------------------------------------------------
// A write beat (tuser 0) stores one box. A query beat (tuser 1) with n boxes
// in the union runs a minimum pass that reads each box, forms its distance
// and updates the minimum, then a sum pass that reads each box again and,
// for each box within 16 temperatures of the minimum, runs the divider
// (one bit a cycle) and adds its exp term; then come the leading-one shift,
// the log and the correction; a query on an empty union skips all of this.
// Both passes read the single read port of the box table once per box. A
// finished result waits in the output register while the next beat is taken.
`include "box_field_smooth_union_unit_defines.svh"

module box_field_smooth_union_unit #(
  parameter int MAX_BOXES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [30:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // box_index, center_x, center_z, half_width, half_depth, query_x, query_z
  input  logic [199:0] in_tdata,
  // req_type
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // distance
  output logic [31:0]  out_tdata,
  // empty_res
  output logic [0:0]   out_tuser
);

  bfsu_pkg::cmd_t    cmd;
  bfsu_pkg::status_t st;

  bfsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bfsu_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .st         (st)
  );

  `BFSU_ASSERT_SAME(a_empty_max, out_tvalid && out_tuser[0], out_tdata == 32'h7FFFFFFF, "empty result without saturated distance")
  `BFSU_ASSERT_NEXT(a_query_busy, in_tvalid && in_tready && in_tuser[0], !in_tready, "query beat did not leave idle")
  `BFSU_ASSERT_NEXT(a_write_ready, in_tvalid && in_tready && !in_tuser[0], in_tready, "write beat did not return to idle")

endmodule
